FILE: hw/rtl/ilt_pkg.sv
package ilt_pkg;

	localparam int POS_W = 7;

	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_HASH    = 8'h23;
	localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
	localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
	localparam logic [7:0] CHAR_RBRACK  = 8'h5D;

	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		CLS_UNDECIDED = 2'd0,
		CLS_IGNORED   = 2'd1,
		CLS_SECTION   = 2'd2,
		CLS_KEYVAL    = 2'd3
	} line_class_t;

	localparam logic KIND_SECTION = 1'b0;
	localparam logic KIND_KEYVAL  = 1'b1;

	typedef struct packed {
		pos_t        line_position;
		logic        leading_done;
		line_class_t line_class;
		logic        text_ended;
		logic        delimiter_seen;
		pos_t        span_one_start;
		pos_t        span_one_end;
		pos_t        span_two_start;
		pos_t        span_two_end;
		logic        value_lead_done;
	} line_state_t;

	typedef struct packed {
		logic line_kind;
		pos_t name_start;
		pos_t name_end;
		pos_t value_start;
		pos_t value_end;
	} token_t;

endpackage

FILE: hw/rtl/ini_line_tokenizer_core.sv
// INI line tokenizer.
// Input channel (text_valid/text_ready): one byte of text per transfer, or an
// end-of-input marker (end_of_input = 1, byte ignored). Byte 10 ends a line.
// Output channel (token_valid/token_ready): one token per section line or
// key=value line, carrying the kind and the name and value spans as byte
// positions within the line. Blank lines, comments and key=value lines with
// no '=' or no key give no token. Only the first LINE_CHARS-1 bytes of a line
// are kept. Each byte is classified in the cycle it is transferred; the line
// state and the token register update at that edge, so a token appears in the
// cycle after the newline or end marker that closes its line.
// Throughput is one byte per cycle: the token register frees in the same
// cycle it is taken, so text_ready stays high unless a token is waiting
// and token_ready is low. While the receiver stalls, the token holds and
// the input is held off; nothing is dropped.
// Reset (arst_n low) clears the line state and empties the token register;
// the first byte may be sent in the cycle after reset is released.
module ini_line_tokenizer_core #(
	parameter int LINE_CHARS = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_ready,
	input  logic [7:0]          text_byte,
	input  logic                end_of_input,
	output logic                token_valid,
	input  logic                token_ready,
	output logic                line_kind,
	output ilt_pkg::pos_t       name_start,
	output ilt_pkg::pos_t       name_end,
	output ilt_pkg::pos_t       value_start,
	output ilt_pkg::pos_t       value_end
);
	import ilt_pkg::*;

	localparam pos_t POS_LIMIT = POS_W'(LINE_CHARS - 1);

	line_state_t st_q;
	line_state_t st_d;
	token_t      tok_d;
	token_t      tok_q;
	logic        tok_hit;
	logic        out_valid_q;
	logic        in_xfer;
	pos_t        p;
	pos_t        p_inc;

	assign text_ready = !out_valid_q || token_ready;
	assign in_xfer    = text_valid && text_ready;
	assign p          = st_q.line_position;
	assign p_inc      = p + POS_W'(1);

	always_comb begin
		st_d    = st_q;
		tok_d   = '0;
		tok_hit = 1'b0;
		if (end_of_input || text_byte == CHAR_NEWLINE) begin
			// close the line and emit a token if it qualifies
			if (st_q.line_class == CLS_SECTION) begin
				tok_hit          = 1'b1;
				tok_d.line_kind  = KIND_SECTION;
				tok_d.name_start = st_q.value_lead_done ? st_q.span_one_start : p;
				tok_d.name_end   = st_q.value_lead_done ? st_q.span_one_end : p;
			end else if (st_q.line_class == CLS_KEYVAL && st_q.delimiter_seen &&
					st_q.span_one_end != st_q.span_one_start) begin
				tok_hit           = 1'b1;
				tok_d.line_kind   = KIND_KEYVAL;
				tok_d.name_start  = st_q.span_one_start;
				tok_d.name_end    = st_q.span_one_end;
				tok_d.value_start = st_q.value_lead_done ? st_q.span_two_start : p;
				tok_d.value_end   = st_q.value_lead_done ? st_q.span_two_end : p;
			end
			st_d = '0;
		end else if (!st_q.text_ended && p < POS_LIMIT) begin
			if (text_byte == CHAR_NUL) begin
				st_d.text_ended = 1'b1;
			end else begin
				st_d.line_position = p_inc;
				if (!st_q.leading_done) begin
					if (text_byte != CHAR_SPACE) begin
						st_d.leading_done = 1'b1;
						if (text_byte == CHAR_HASH) begin
							st_d.line_class = CLS_IGNORED;
						end else if (text_byte == CHAR_LBRACK) begin
							st_d.line_class = CLS_SECTION;
						end else begin
							st_d.line_class     = CLS_KEYVAL;
							st_d.span_one_start = p;
							if (text_byte == CHAR_EQUALS) begin
								st_d.span_one_end   = p;
								st_d.delimiter_seen = 1'b1;
							end else begin
								st_d.span_one_end = p_inc;
							end
						end
					end
				end else if (st_q.line_class == CLS_SECTION) begin
					if (!st_q.delimiter_seen) begin
						if (text_byte == CHAR_RBRACK) begin
							st_d.delimiter_seen = 1'b1;
							if (!st_q.value_lead_done) begin
								st_d.value_lead_done = 1'b1;
								st_d.span_one_start  = p;
								st_d.span_one_end    = p;
							end
						end else if (text_byte != CHAR_SPACE) begin
							if (!st_q.value_lead_done) begin
								st_d.value_lead_done = 1'b1;
								st_d.span_one_start  = p;
							end
							st_d.span_one_end = p_inc;
						end
					end
				end else if (st_q.line_class == CLS_KEYVAL) begin
					if (!st_q.delimiter_seen) begin
						if (text_byte == CHAR_EQUALS) begin
							st_d.delimiter_seen = 1'b1;
						end else if (text_byte != CHAR_SPACE) begin
							st_d.span_one_end = p_inc;
						end
					end else if (text_byte != CHAR_SPACE) begin
						if (!st_q.value_lead_done) begin
							st_d.value_lead_done = 1'b1;
							st_d.span_two_start  = p;
						end
						st_d.span_two_end = p_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			st_q        <= st_d;
			out_valid_q <= tok_hit;
		end else if (token_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the token payload until a new one is loaded
	always_ff @(posedge clk) begin
		if (in_xfer && tok_hit) begin
			tok_q <= tok_d;
		end
	end

	assign token_valid = out_valid_q;
	assign line_kind   = tok_q.line_kind;
	assign name_start  = tok_q.name_start;
	assign name_end    = tok_q.name_end;
	assign value_start = tok_q.value_start;
	assign value_end   = tok_q.value_end;

endmodule

FILE: hw/rtl/ilt_checker.sv
module ilt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                text_ready,
	input logic                token_valid,
	input logic                token_ready,
	input logic                line_kind,
	input ilt_pkg::pos_t       name_start,
	input ilt_pkg::pos_t       name_end,
	input ilt_pkg::pos_t       value_start,
	input ilt_pkg::pos_t       value_end
);
	import ilt_pkg::*;

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid)
		else $error("token dropped while stalled");

	a_tok_stable: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> $stable(name_start) && $stable(name_end) &&
			$stable(value_start) && $stable(value_end) && $stable(line_kind))
		else $error("token payload changed while stalled");

	// input is held off only by a waiting, stalled token
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!text_ready |-> token_valid && !token_ready)
		else $error("input stalled without output backpressure");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> name_start <= name_end && value_start <= value_end)
		else $error("span end before start");

	// key spans are never empty and the value never starts before the key ends
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> (line_kind == KIND_SECTION && value_start == '0 && value_end == '0)
			|| (line_kind == KIND_KEYVAL && name_start < name_end
				&& name_end <= value_start))
		else $error("token fields inconsistent with kind");

endmodule

bind ini_line_tokenizer_core ilt_checker u_ilt_checker (.*);
